@@ sv/bgrr_pkg.sv @@
// Shared types and constants for the bitmap glyph row renderer.
`default_nettype none

package bgrr_pkg;

  // Field widths
  localparam int unsigned ROWS_W   = 6;
  localparam int unsigned SCREEN_W = 13;
  localparam int unsigned STRIDE_W = 14;
  localparam int unsigned ADDR_W   = 13;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned INDEX_W  = 26;
  localparam int unsigned COLS     = 8;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned STORE_DEPTH = 8192;
  localparam int unsigned MAX_ROWS_DEF = 32;

  // Register reset values
  localparam logic [ROWS_W-1:0]   GLYPH_ROWS_RST    = 6'd16;
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST    = 14'd1024;

  // Function codes of an input transaction
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GLYPH_ROWS    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2,
    CFG_ROW_STRIDE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ROWS_W-1:0]   glyph_rows;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [STRIDE_W-1:0] row_stride_words;
  } cfg_t;

  // One classified draw job as handed from the front end to the back end
  typedef struct packed {
    logic [ADDR_W-1:0]   base_addr;
    logic [ROWS_W-1:0]   rows;
    logic [SCREEN_W-1:0] y;
    logic [INDEX_W-1:0]  idx;
    logic [COLS-1:0]     col_mask;
    logic [COLOR_W-1:0]  fg;
    logic [COLOR_W-1:0]  bg;
  } job_t;

  // Occupancy seen by the front end
  typedef struct packed {
    logic queue_empty;
    logic queue_full;
    logic back_busy;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/bgrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bgrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/bgrr_front.sv @@
// Front end: accepts transactions, writes glyph bytes, turns draws into jobs.
`default_nettype none

module bgrr_front #(
  parameter int unsigned MAX_GLYPH_ROWS = bgrr_pkg::MAX_ROWS_DEF
) (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          func,
  input  wire logic [bgrr_pkg::ADDR_W-1:0]   store_index,
  input  wire logic [7:0]                    store_byte,
  input  wire logic [bgrr_pkg::CODE_W-1:0]   char_code,
  input  wire logic [bgrr_pkg::POS_W-1:0]    pos_x,
  input  wire logic [bgrr_pkg::POS_W-1:0]    pos_y,
  input  wire logic [bgrr_pkg::COLOR_W-1:0]  fore_color,
  input  wire logic [bgrr_pkg::COLOR_W-1:0]  back_color,
  input  wire bgrr_pkg::cfg_t                cfg,
  input  wire bgrr_pkg::stat_t               stat,
  output logic                               ram_we,
  output logic [bgrr_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [7:0]                         ram_wdata,
  output logic                               push,
  output bgrr_pkg::job_t                     job
);

  import bgrr_pkg::*;

  localparam logic [ROWS_W-1:0] MaxRows = ROWS_W'(MAX_GLYPH_ROWS);

  logic                      is_draw;
  logic                      accept;
  logic [ROWS_W-1:0]         rows_eff;
  logic [ADDR_W+ROWS_W-1:0]  base_prod;
  logic [INDEX_W-1:0]        idx_prod;
  logic [COLS-1:0]           col_mask;
  logic [SCREEN_W-1:0]       col_x [COLS];

  // Clamp the row count to what the block supports
  assign rows_eff = (cfg.glyph_rows > MaxRows) ? MaxRows : cfg.glyph_rows;

  // Loads wait until every earlier draw has read the store
  assign is_draw  = (func == FUNC_DRAW);
  assign in_stall = is_draw ? stat.queue_full : (!stat.queue_empty || stat.back_busy);
  assign accept   = in_valid && !in_stall;

  assign ram_we    = accept && !is_draw;
  assign ram_waddr = store_index;
  assign ram_wdata = store_byte;

  // Drop draws with zero rows
  assign push = accept && is_draw && (rows_eff != '0);

  // Glyph base address and first pixel index
  assign base_prod = {{ROWS_W{1'b0}}, 5'd0, char_code} * {{(ADDR_W){1'b0}}, rows_eff};
  assign idx_prod  = INDEX_W'(pos_y) * INDEX_W'(cfg.row_stride_words) + INDEX_W'(pos_x);

  // Horizontal clip per column
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_x[c]    = {1'b0, pos_x} + SCREEN_W'(c);
      col_mask[c] = (col_x[c] < cfg.screen_width);
    end
  end

  always_comb begin
    job.base_addr = base_prod[ADDR_W-1:0];
    job.rows      = rows_eff;
    job.y         = {1'b0, pos_y};
    job.idx       = idx_prod;
    job.col_mask  = col_mask;
    job.fg        = fore_color;
    job.bg        = back_color;
  end

endmodule

`default_nettype wire

@@ sv/bgrr_queue.sv @@
// Two-entry job queue between the front end and the back end.
`default_nettype none

module bgrr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bgrr_pkg::job_t push_job,
  input  wire logic           pop,
  output bgrr_pkg::job_t      pop_job,
  output logic                empty,
  output logic                full
);

  import bgrr_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign pop_job = slot[rd_ptr];

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store the job
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ sv/bgrr_back.sv @@
// Back end: walks the glyph rows of a job, reads the store, emits row results.
`default_nettype none

module bgrr_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bgrr_pkg::cfg_t                 cfg,
  input  wire logic                           q_empty,
  input  wire bgrr_pkg::job_t                 q_job,
  output logic                                q_pop,
  output logic                                busy,
  output logic                                ram_re,
  output logic [bgrr_pkg::ADDR_W-1:0]         ram_raddr,
  input  wire logic [7:0]                     ram_rdata,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bgrr_pkg::INDEX_W-1:0]        row_pixel_index,
  output logic [bgrr_pkg::COLS-1:0]           write_mask,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_0,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_1,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_2,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_3,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_4,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_5,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_6,
  output logic [bgrr_pkg::COLOR_W-1:0]        color_7,
  output logic                                last_row
);

  import bgrr_pkg::*;

  job_t                cur;
  logic [ROWS_W-1:0]   row;
  logic                issue;
  logic                is_last;
  logic                out_ready;

  logic                s2_valid;
  logic [INDEX_W-1:0]  s2_idx;
  logic [COLS-1:0]     s2_mask;
  logic [COLOR_W-1:0]  s2_fg;
  logic [COLOR_W-1:0]  s2_bg;
  logic                s2_last;
  logic [COLOR_W-1:0]  pix [COLS];

  assign out_ready = !out_valid || !out_stall;
  assign issue     = busy && (!s2_valid || out_ready);
  assign is_last   = ((row + ROWS_W'(1)) == cur.rows);
  assign q_pop     = !q_empty && (!busy || (issue && is_last));

  assign ram_re    = issue;
  assign ram_raddr = cur.base_addr + ADDR_W'(row);

  // Row sequencer: load a job, then step one row per issued read
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (issue && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
      row <= '0;
    end else if (issue) begin
      row     <= row + ROWS_W'(1);
      cur.y   <= cur.y + SCREEN_W'(1);
      cur.idx <= cur.idx + INDEX_W'(cfg.row_stride_words);
    end
  end

  // Read stage: row metadata waits here for the store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (issue) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_idx  <= cur.idx;
      s2_mask <= (cur.y < cfg.screen_height) ? cur.col_mask : '0;
      s2_fg   <= cur.fg;
      s2_bg   <= cur.bg;
      s2_last <= is_last;
    end
  end

  // Expand glyph bits to colors, MSB is column 0
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      pix[c] = ram_rdata[COLS-1-c] ? s2_fg : s2_bg;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      row_pixel_index <= s2_idx;
      write_mask      <= s2_mask;
      color_0         <= pix[0];
      color_1         <= pix[1];
      color_2         <= pix[2];
      color_3         <= pix[3];
      color_4         <= pix[4];
      color_5         <= pix[5];
      color_6         <= pix[6];
      color_7         <= pix[7];
      last_row        <= s2_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/bitmap_glyph_row_renderer.sv @@
// Top level of the bitmap glyph row renderer.
//
// Character generator for 8-pixel-wide one-bit glyphs held in an 8192-byte
// glyph store. A load transaction (func 0) writes one store byte; it is
// accepted only once every earlier draw has finished reading the store. A
// draw transaction (func 1) is classified in the front end and queued (two
// jobs deep); the back end then reads one glyph row per cycle from the
// store's single read port while its output is not stalled, one read per
// row of the draw (16 rows with the reset font height). Each row passes the
// read stage and then the output register. Draws with zero rows give no
// result. Each result carries the row's word index, a clip mask and eight
// colors, and last_row marks the final row of a character.
`default_nettype none

module bitmap_glyph_row_renderer #(
  parameter int unsigned MAX_GLYPH_ROWS = bgrr_pkg::MAX_ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [bgrr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             func,
  input  wire logic [bgrr_pkg::ADDR_W-1:0]      store_index,
  input  wire logic [7:0]                       store_byte,
  input  wire logic [bgrr_pkg::CODE_W-1:0]      char_code,
  input  wire logic [bgrr_pkg::POS_W-1:0]       pos_x,
  input  wire logic [bgrr_pkg::POS_W-1:0]       pos_y,
  input  wire logic [bgrr_pkg::COLOR_W-1:0]     fore_color,
  input  wire logic [bgrr_pkg::COLOR_W-1:0]     back_color,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bgrr_pkg::INDEX_W-1:0]          row_pixel_index,
  output logic [bgrr_pkg::COLS-1:0]             write_mask,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_0,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_1,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_2,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_3,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_4,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_5,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_6,
  output logic [bgrr_pkg::COLOR_W-1:0]          color_7,
  output logic                                  last_row
);

  import bgrr_pkg::*;

  cfg_t                cfg;
  stat_t               stat;
  logic                push;
  job_t                push_job;
  logic                pop;
  job_t                pop_job;
  logic                q_empty;
  logic                q_full;
  logic                back_busy;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_rows       <= GLYPH_ROWS_RST;
      cfg.screen_width     <= SCREEN_WIDTH_RST;
      cfg.screen_height    <= SCREEN_HEIGHT_RST;
      cfg.row_stride_words <= ROW_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GLYPH_ROWS:    cfg.glyph_rows       <= cfg_data[ROWS_W-1:0];
        CFG_SCREEN_WIDTH:  cfg.screen_width     <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height    <= cfg_data[SCREEN_W-1:0];
        CFG_ROW_STRIDE:    cfg.row_stride_words <= cfg_data[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.queue_empty = q_empty;
    stat.queue_full  = q_full;
    stat.back_busy   = back_busy;
  end

  bgrr_front #(
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .store_index (store_index),
    .store_byte  (store_byte),
    .char_code   (char_code),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .fore_color  (fore_color),
    .back_color  (back_color),
    .cfg         (cfg),
    .stat        (stat),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .push        (push),
    .job         (push_job)
  );

  bgrr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  bgrr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgrr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (pop),
    .busy            (back_busy),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .row_pixel_index (row_pixel_index),
    .write_mask      (write_mask),
    .color_0         (color_0),
    .color_1         (color_1),
    .color_2         (color_2),
    .color_3         (color_3),
    .color_4         (color_4),
    .color_5         (color_5),
    .color_6         (color_6),
    .color_7         (color_7),
    .last_row        (last_row)
  );

endmodule

`default_nettype wire

@@ sv/bgrr_checker.sv @@
// Port-level checks for the bitmap glyph row renderer, bound to the top level.
`default_nettype none

module bgrr_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [25:0] row_pixel_index,
  input  wire logic [7:0]  write_mask,
  input  wire logic        last_row
);

  // Reset empties the output
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_pixel_index) &&
      $stable(write_mask) && $stable(last_row))
    else $error("stalled result changed");

  // Visible columns always form a run starting at column 0
  a_mask_prefix: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((write_mask & (write_mask + 8'd1)) == 8'd0))
    else $error("write mask is not a left-aligned run");

endmodule

bind bitmap_glyph_row_renderer bgrr_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .row_pixel_index (row_pixel_index),
  .write_mask      (write_mask),
  .last_row        (last_row)
);

`default_nettype wire
